>>> hdl/ldd_pkg.sv
// ----------------------------------------------------------------------------
// ldd_pkg
// Shared constants and types of the layered decision diagram builder.
// ----------------------------------------------------------------------------
package ldd_pkg;

    localparam int MAX_LOG_SIZE = 12;
    localparam int NODE_CAP     = 1024;
    localparam int LEAF_BITS    = 8;

    localparam int LAYER_W = 4;
    localparam int NODE_W  = 10;
    localparam int CNT_W   = 11;
    localparam int LEAF_W  = 8;

    localparam int STORE_DEPTH = MAX_LOG_SIZE * NODE_CAP;
    localparam int STORE_AW    = LAYER_W + NODE_W;
    localparam int STORE_W     = 2 * NODE_W;

    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [NODE_W-1:0]  number;
        logic [NODE_W-1:0]  low;
        logic [NODE_W-1:0]  high;
        logic               done;
    } rec_t;

endpackage

>>> hdl/ldd_ram.sv
// ----------------------------------------------------------------------------
// ldd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ldd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/layered_decision_diagram_builder_core.sv
// ----------------------------------------------------------------------------
// layered_decision_diagram_builder_core
// Builds a layered decision diagram from table leaves, one leaf per transfer.
// ----------------------------------------------------------------------------
// Leaves enter on the s_ channel in table index order. Each leaf climbs the
// layers: at a layer with a waiting left element the pair is searched in that
// layer's pair store; a new pair becomes a node, if the layer has room, and
// yields one record on the m_ channel. The record of the top layer carries
// m_table_done and ends the table. The cfg channel writes the table size
// (log2) and abandons any table in progress; it is taken only when idle.
// Each visited layer passes S_LAYER, each stored pair compared passes S_RD and
// S_CMP, and a new pair one more S_RD, set by the single read port of the
// pair store and one comparator shared by all layers; the records of a leaf
// then leave one per cycle while m_ready is high.
// s_ready is low from acceptance until the last record of the leaf has been
// transferred, so a stalled receiver holds the whole block.
// Reset clears the held elements, node counts and flags and sets the table
// size to 12; the pair store needs no clearing since only entries below the
// node count of a layer are ever read.
// ----------------------------------------------------------------------------
module layered_decision_diagram_builder_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [3:0]                   cfg_table_log_size,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ldd_pkg::LEAF_W-1:0]   s_leaf_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ldd_pkg::LAYER_W-1:0]  m_node_layer,
    output logic [ldd_pkg::NODE_W-1:0]   m_node_number,
    output logic [ldd_pkg::NODE_W-1:0]   m_low_child,
    output logic [ldd_pkg::NODE_W-1:0]   m_high_child,
    output logic                         m_last_of_run,
    output logic                         m_table_done,
    output logic                         m_layer_overflow
);
    import ldd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LAYER = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam logic [CNT_W-1:0]   CAP_CNT  = CNT_W'(NODE_CAP);
    localparam logic [NODE_W-1:0]  CAP_LAST = NODE_W'(NODE_CAP - 1);
    localparam logic [LAYER_W-1:0] MAX_LS   = LAYER_W'(MAX_LOG_SIZE);

    logic [2:0]          state_reg;
    logic [3:0]          log_size_reg;
    logic [NODE_W-1:0]   held_child_reg [MAX_LOG_SIZE];
    logic                held_valid_reg [MAX_LOG_SIZE];
    logic [CNT_W-1:0]    nodes_reg      [MAX_LOG_SIZE];
    logic                overflow_reg;
    logic [NODE_W-1:0]   carry_reg;
    logic [NODE_W-1:0]   left_reg;
    logic [LAYER_W-1:0]  layer_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    k_reg;
    logic                top_reg;
    rec_t                rec_reg [MAX_LOG_SIZE];
    logic [LAYER_W-1:0]  n_reg;
    logic [LAYER_W-1:0]  e_reg;

    logic [LAYER_W-1:0]  ls;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [STORE_AW-1:0] rd_addr;
    logic [STORE_W-1:0]  rd_data;
    logic                is_top;
    rec_t                cur_rec;

    always_comb begin
        if (log_size_reg == 4'd0) begin
            ls = LAYER_W'(1);
        end else if (log_size_reg > MAX_LS) begin
            ls = MAX_LS;
        end else begin
            ls = log_size_reg;
        end
    end

    assign is_top  = (layer_reg + LAYER_W'(1)) == ls;
    assign wr_en   = (state_reg == S_RD) && (k_reg == cnt_reg) && (cnt_reg < CAP_CNT);
    assign wr_addr = {layer_reg, cnt_reg[NODE_W-1:0]};
    assign rd_addr = {layer_reg, k_reg[NODE_W-1:0]};

    ldd_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_pair_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({left_reg, carry_reg}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign m_valid   = (state_reg == S_EMIT) && (n_reg != '0);

    assign cur_rec          = rec_reg[e_reg];
    assign m_node_layer     = cur_rec.layer;
    assign m_node_number    = cur_rec.number;
    assign m_low_child      = cur_rec.low;
    assign m_high_child     = cur_rec.high;
    assign m_table_done     = cur_rec.done;
    assign m_last_of_run    = (e_reg + LAYER_W'(1)) == n_reg;
    assign m_layer_overflow = overflow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            log_size_reg <= 4'd12;
            overflow_reg <= 1'b0;
            n_reg        <= '0;
            e_reg        <= '0;
            top_reg      <= 1'b0;
            for (int i = 0; i < MAX_LOG_SIZE; i++) begin
                held_child_reg[i] <= '0;
                held_valid_reg[i] <= 1'b0;
                nodes_reg[i]      <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cfg_valid) begin
                        log_size_reg <= cfg_table_log_size;
                        overflow_reg <= 1'b0;
                        for (int i = 0; i < MAX_LOG_SIZE; i++) begin
                            held_child_reg[i] <= '0;
                            held_valid_reg[i] <= 1'b0;
                            nodes_reg[i]      <= '0;
                        end
                    end else if (s_valid) begin
                        carry_reg <= NODE_W'(s_leaf_value);
                        layer_reg <= '0;
                        n_reg     <= '0;
                        e_reg     <= '0;
                        top_reg   <= 1'b0;
                        state_reg <= S_LAYER;
                    end
                end
                S_LAYER: begin
                    if (layer_reg == ls) begin
                        state_reg <= S_EMIT;
                    end else if (!held_valid_reg[layer_reg]) begin
                        held_child_reg[layer_reg] <= carry_reg;
                        held_valid_reg[layer_reg] <= 1'b1;
                        state_reg                 <= S_EMIT;
                    end else begin
                        left_reg                  <= held_child_reg[layer_reg];
                        held_valid_reg[layer_reg] <= 1'b0;
                        cnt_reg   <= (nodes_reg[layer_reg] > CAP_CNT) ? CAP_CNT
                                                                      : nodes_reg[layer_reg];
                        k_reg     <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    if (k_reg == cnt_reg) begin
                        if (cnt_reg < CAP_CNT) begin
                            rec_reg[n_reg].layer  <= layer_reg;
                            rec_reg[n_reg].number <= cnt_reg[NODE_W-1:0];
                            rec_reg[n_reg].low    <= left_reg;
                            rec_reg[n_reg].high   <= carry_reg;
                            rec_reg[n_reg].done   <= is_top;
                            n_reg                 <= n_reg + LAYER_W'(1);
                            carry_reg             <= cnt_reg[NODE_W-1:0];
                            nodes_reg[layer_reg]  <= cnt_reg + CNT_W'(1);
                        end else begin
                            overflow_reg <= 1'b1;
                            carry_reg    <= CAP_LAST;
                        end
                        if (is_top) begin
                            top_reg <= 1'b1;
                        end
                        layer_reg <= layer_reg + LAYER_W'(1);
                        state_reg <= S_LAYER;
                    end else begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (rd_data == {left_reg, carry_reg}) begin
                        carry_reg <= k_reg[NODE_W-1:0];
                        if (is_top) begin
                            top_reg <= 1'b1;
                        end
                        layer_reg <= layer_reg + LAYER_W'(1);
                        state_reg <= S_LAYER;
                    end else begin
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= S_RD;
                    end
                end
                S_EMIT: begin
                    if ((n_reg == '0) || (m_ready && m_last_of_run)) begin
                        if (top_reg) begin
                            overflow_reg <= 1'b0;
                            for (int i = 0; i < MAX_LOG_SIZE; i++) begin
                                held_child_reg[i] <= '0;
                                held_valid_reg[i] <= 1'b0;
                                nodes_reg[i]      <= '0;
                            end
                        end
                        state_reg <= S_IDLE;
                    end else if (m_ready) begin
                        e_reg <= e_reg + LAYER_W'(1);
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> bench/layered_decision_diagram_builder_core_test.sv
// ----------------------------------------------------------------------------
// layered_decision_diagram_builder_core_test
// Self-checking bench: a directed table of leaves and size writes, then
// random tables of many sizes, each record compared against a behavioral
// node-building predictor (hand-written records for the directed root pairs).
// ----------------------------------------------------------------------------
module layered_decision_diagram_builder_core_test;
    import ldd_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;

    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [NODE_W-1:0]  number;
        logic [NODE_W-1:0]  low;
        logic [NODE_W-1:0]  high;
        logic               last;
        logic               done;
        logic               ovf;
    } node_rec_t;

    typedef enum logic {ROW_SIZE, ROW_LEAF} row_kind_e;

    typedef struct {
        row_kind_e kind;
        logic [7:0] val;
        bit        typed;
        node_rec_t rec;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_table_log_size = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [LEAF_W-1:0] s_leaf_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [LAYER_W-1:0] m_node_layer;
    logic [NODE_W-1:0] m_node_number;
    logic [NODE_W-1:0] m_low_child;
    logic [NODE_W-1:0] m_high_child;
    logic m_last_of_run;
    logic m_table_done;
    logic m_layer_overflow;

    layered_decision_diagram_builder_core u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_table_log_size (cfg_table_log_size),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_leaf_value       (s_leaf_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_node_layer       (m_node_layer),
        .m_node_number      (m_node_number),
        .m_low_child        (m_low_child),
        .m_high_child       (m_high_child),
        .m_last_of_run      (m_last_of_run),
        .m_table_done       (m_table_done),
        .m_layer_overflow   (m_layer_overflow)
    );

    always #2 aclk = ~aclk;

    // node-building state
    logic [3:0]        size_reg;
    logic [NODE_W-1:0] held_child [MAX_LOG_SIZE];
    bit                held_full [MAX_LOG_SIZE];
    int                layer_count [MAX_LOG_SIZE];
    logic [NODE_W-1:0] pair_low [MAX_LOG_SIZE][NODE_CAP];
    logic [NODE_W-1:0] pair_high [MAX_LOG_SIZE][NODE_CAP];
    bit                cap_hit;

    node_rec_t pending_nodes[$];
    stim_row_t dir_rows[$];
    bit        failed = 1'b0;
    bit        send_burst = 1'b0;
    bit        recv_burst = 1'b0;

    function automatic void abandon_table();
        for (int i = 0; i < MAX_LOG_SIZE; i++) begin
            held_child[i] = '0;
            held_full[i] = 1'b0;
            layer_count[i] = 0;
        end
        cap_hit = 1'b0;
    endfunction

    function automatic void set_table_size(logic [3:0] v);
        size_reg = v;
        abandon_table();
    endfunction

    // climb the layers with one leaf; return the new nodes it makes
    function automatic void build_nodes(logic [7:0] leaf, ref node_rec_t out[$]);
        int ls;
        int carry;
        int left;
        int cnt;
        int k;
        bit found;
        bit top_paired;
        out.delete();
        ls = (size_reg < 1) ? 1 : (size_reg > MAX_LOG_SIZE) ? MAX_LOG_SIZE : int'(size_reg);
        carry = int'(leaf);
        top_paired = 1'b0;
        for (int lay = 0; lay < ls; lay++) begin
            if (!held_full[lay]) begin
                held_child[lay] = NODE_W'(carry);
                held_full[lay] = 1'b1;
                break;
            end
            left = int'(held_child[lay]);
            held_full[lay] = 1'b0;
            cnt = layer_count[lay];
            found = 1'b0;
            for (k = 0; k < cnt; k++) begin
                if (pair_low[lay][k] == left && pair_high[lay][k] == carry) begin
                    found = 1'b1;
                    break;
                end
            end
            if (found) begin
                carry = k;
            end else if (cnt < NODE_CAP) begin
                pair_low[lay][cnt] = NODE_W'(left);
                pair_high[lay][cnt] = NODE_W'(carry);
                out.push_back('{layer: LAYER_W'(lay), number: NODE_W'(cnt),
                                low: NODE_W'(left), high: NODE_W'(carry),
                                last: 0, done: 0, ovf: 0});
                carry = cnt;
                layer_count[lay] = cnt + 1;
            end else begin
                cap_hit = 1'b1;
                carry = NODE_CAP - 1;
            end
            if (lay + 1 == ls) top_paired = 1'b1;
        end
        foreach (out[i]) begin
            out[i].last = (i == out.size() - 1);
            out[i].done = top_paired && (out[i].layer + 1 == ls);
            out[i].ovf = cap_hit;
        end
        if (top_paired) abandon_table();
    endfunction

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 19);
        if (burst || r < 11) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_leaf(logic [7:0] v, bit typed, node_rec_t typed_rec);
        node_rec_t made[$];
        int gap;
        gap = pick_gap(send_burst);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_leaf_value = v;
        do @(posedge aclk); while (!s_ready);
        build_nodes(v, made);
        if (typed) pending_nodes.push_back(typed_rec);
        else foreach (made[i]) pending_nodes.push_back(made[i]);
        @(negedge aclk);
    endtask

    task automatic write_size(logic [3:0] v);
        s_valid = 1'b0;
        wait (pending_nodes.size() == 0);
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_table_log_size = v;
        do @(posedge aclk); while (!cfg_ready);
        set_table_size(v);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic void add_size(logic [3:0] v);
        dir_rows.push_back('{kind: ROW_SIZE, val: v, typed: 0, rec: '0});
    endfunction

    function automatic void add_leaf(logic [7:0] v);
        dir_rows.push_back('{kind: ROW_LEAF, val: v, typed: 0, rec: '0});
    endfunction

    // two-leaf table: pair becomes root node 0 of layer 0
    function automatic void add_root_pair(logic [7:0] a, logic [7:0] b);
        add_leaf(a);
        dir_rows.push_back('{kind: ROW_LEAF, val: b, typed: 1,
            rec: '{layer: 0, number: 0, low: a, high: b, last: 1, done: 1, ovf: 0}});
    endfunction

    // receiver stalls
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
            end else begin
                hold = pick_gap(recv_burst);
                m_ready = (hold == 0);
            end
        end
    end

    always @(posedge aclk) begin
        node_rec_t got;
        node_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_node_layer, m_node_number, m_low_child, m_high_child,
                    m_last_of_run, m_table_done, m_layer_overflow};
            if (pending_nodes.size() == 0) begin
                $display("%0t: unexpected record %p", $time, got);
                failed = 1'b1;
            end else begin
                want = pending_nodes.pop_front();
                if (got !== want) begin
                    $display("%0t: record mismatch expected %p actual %p", $time, want, got);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        int idle_cycles;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("layered_decision_diagram_builder_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        int ls;
        int len;
        int mode;
        logic [7:0] v;
        int sizes [10] = '{1, 2, 3, 4, 5, 0, 15, 3, 6, 2};

        set_table_size(4'd12);
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        add_size(4'd1);
        add_root_pair(8'd0, 8'd255);
        add_root_pair(8'd255, 8'd0);
        add_root_pair(8'd170, 8'd85);
        add_size(4'd0);
        add_root_pair(8'd7, 8'd7);
        add_size(4'd2);
        add_leaf(8'd1); add_leaf(8'd2); add_leaf(8'd1); add_leaf(8'd2);
        add_leaf(8'd255); add_leaf(8'd255); add_leaf(8'd0); add_leaf(8'd255);
        add_size(4'd15);
        add_leaf(8'd9); add_leaf(8'd9); add_leaf(8'd9); add_leaf(8'd9);
        add_size(4'd3);
        add_leaf(8'd4); add_leaf(8'd4); add_leaf(8'd4); add_leaf(8'd4);
        add_leaf(8'd4); add_leaf(8'd4); add_leaf(8'd4); add_leaf(8'd5);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_SIZE) write_size(dir_rows[i].val[3:0]);
            else send_leaf(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].rec);
        end

        // random tables
        sent = 0;
        while (sent < 392) begin
            foreach (sizes[p]) begin
                if (sent >= 392) break;
                write_size(4'(sizes[p]));
                ls = (sizes[p] < 1) ? 1 : (sizes[p] > MAX_LOG_SIZE) ? MAX_LOG_SIZE : sizes[p];
                send_burst = ($urandom_range(0, 3) == 0);
                recv_burst = ($urandom_range(0, 3) == 0);
                for (int t = 0; t < 3; t++) begin
                    len = (ls > 6) ? $urandom_range(20, 60) : (1 << ls);
                    // occasionally cut the table short
                    if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
                    mode = $urandom_range(0, 2);
                    for (int j = 0; j < len && sent < 392; j++) begin
                        case (mode)
                            0: v = 8'($urandom_range(0, 255));
                            1: v = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
                            default: v = 8'($urandom_range(0, 3) * 85);
                        endcase
                        send_leaf(v, 0, '0);
                        sent++;
                    end
                    if (len < (1 << ls) || sent >= 392) break;
                end
            end
        end

        s_valid = 1'b0;
        wait (pending_nodes.size() == 0);
        repeat (40) @(posedge aclk);
        if (!failed) begin
            $display("layered_decision_diagram_builder_core verification clean");
        end else begin
            $display("layered_decision_diagram_builder_core verification failed");
        end
        $finish;
    end

endmodule
